/* rtl/core/ttdec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdec_pkg: shared types and constants of the tiled texel decoder
// Coding modes, register indexes, the front-to-back queue entry, the result
// record and the RGB5A3 color expansion.
// ----------------------------------------------------------------------------
package ttdec_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_DIMENSION_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 10;
    localparam int COLOR_W    = 8;
    localparam int WORD_W     = 16;
    localparam int INDEX_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int OPAQUE_BIT = 15;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUTQ_DEPTH  = 8;
    localparam int OQ_PTR_W    = $clog2(OUTQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        MODE_RGB5A3 = 3'd0,
        MODE_PAL4   = 3'd1,
        MODE_PAL8   = 3'd2,
        MODE_INT4   = 3'd3,
        MODE_INT8   = 3'd4
    } coding_t;

    typedef enum logic [1:0] {
        TEXEL_WORD    = 2'd0,
        TEXEL_PALETTE = 2'd1,
        TEXEL_ALPHA   = 2'd2
    } texel_kind_t;

    typedef enum logic {
        OP_PAL_LOAD = 1'b0,
        OP_TEXELS   = 1'b1
    } entry_op_t;

    typedef struct packed {
        logic              valid;
        texel_kind_t       kind;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  pix_x;
        logic [POS_W-1:0]  pix_y;
        logic              done;
    } slot_t;

    typedef struct packed {
        entry_op_t          op;
        logic [INDEX_W-1:0] pal_addr;
        slot_t [1:0]        slots;
    } entry_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [POS_W-1:0] pix_x;
        logic [POS_W-1:0] pix_y;
        rgba_t            color;
        logic             image_done;
    } result_t;

    function automatic rgba_t decode_rgb5a3(input logic [WORD_W-1:0] w);
        rgba_t c;
        if (w[OPAQUE_BIT])
        begin
            c.red   = {w[14:10], w[14:12]};
            c.green = {w[9:5], w[9:7]};
            c.blue  = {w[4:0], w[4:2]};
            c.alpha = 8'hFF;
        end
        else
        begin
            c.red   = {w[11:8], w[11:8]};
            c.green = {w[7:4], w[7:4]};
            c.blue  = {w[3:0], w[3:0]};
            // 3-bit alpha widened by bit replication
            c.alpha = {w[14:12], w[14:12], w[14:13]};
        end
        return c;
    endfunction

endpackage

/* rtl/core/ttdec_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdec_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ttdec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/core/ttdec_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdec_fifo: queue between front and back
// Short register queue of decoded work entries.
// ----------------------------------------------------------------------------
module ttdec_fifo
    import ttdec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t            storage_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = storage_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

/* rtl/core/ttdec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdec_front: input side of the tiled texel decoder
// Holds the configuration, walks the tiles, splits bytes into texels,
// drops padding and queues palette loads and texels for the back end.
// ----------------------------------------------------------------------------
module ttdec_front
    import ttdec_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  req_type,
    input  logic [INDEX_W-1:0]    palette_index,
    input  logic [WORD_W-1:0]     palette_word,
    input  logic [BYTE_W-1:0]     pixel_byte,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output entry_t                q_entry
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int PW = CW + 1;

    coding_t             mode_reg, mode_next;
    logic [CW-1:0]       wm1_reg, wm1_next;
    logic [CW-1:0]       hm1_reg, hm1_next;
    logic [CW-1:0]       tx0_reg, tx0_next;
    logic [CW-1:0]       ty0_reg, ty0_next;
    logic [2:0]          sx_reg, sx_next;
    logic [2:0]          sy_reg, sy_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic                phase_reg, phase_next;

    logic                accept;
    logic                byte_in;
    logic                pal_ok;
    logic                texel;
    logic                two;
    texel_kind_t         kind;
    logic [WORD_W-1:0]   val0, val1;
    logic [3:0]          tile_w, tile_h;
    logic [3:0]          sx_sum, sy_sum;
    logic [PW-1:0]       x0, x1, y0, wl, hl, tx_sum, ty_sum;
    logic [2:0]          cfg_mode;
    logic                v0, v1;

    always_comb
    begin
        accept  = push && !q_full;
        byte_in = accept && req_type;
        pal_ok  = (32'(palette_index) < PALETTE_DEPTH);

        mode_next  = mode_reg;
        wm1_next   = wm1_reg;
        hm1_next   = hm1_reg;
        tx0_next   = tx0_reg;
        ty0_next   = ty0_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        held_next  = held_reg;
        phase_next = phase_reg;

        // classify the byte by coding
        two    = 1'b0;
        kind   = TEXEL_WORD;
        val0   = {held_reg, pixel_byte};
        val1   = '0;
        texel  = byte_in;
        tile_w = 4'd8;
        tile_h = 4'd4;
        case (mode_reg)
            MODE_PAL4:
            begin
                two    = 1'b1;
                kind   = TEXEL_PALETTE;
                val0   = {12'd0, pixel_byte[7:4]};
                val1   = {12'd0, pixel_byte[3:0]};
                tile_h = 4'd8;
            end
            MODE_INT4:
            begin
                two    = 1'b1;
                kind   = TEXEL_ALPHA;
                val0   = {8'd0, pixel_byte[7:4], pixel_byte[7:4]};
                val1   = {8'd0, pixel_byte[3:0], pixel_byte[3:0]};
                tile_h = 4'd8;
            end
            MODE_PAL8:
            begin
                kind = TEXEL_PALETTE;
                val0 = {8'd0, pixel_byte};
            end
            MODE_INT8:
            begin
                kind = TEXEL_ALPHA;
                val0 = {8'd0, pixel_byte};
            end
            default:
            begin
                // high byte of a big-endian word is held until the low one arrives
                tile_w = 4'd4;
                texel  = byte_in && phase_reg;
                if (byte_in)
                begin
                    phase_next = !phase_reg;
                    if (!phase_reg)
                    begin
                        held_next = pixel_byte;
                    end
                end
            end
        endcase

        x0 = PW'(tx0_reg) + PW'(sx_reg);
        x1 = x0 + PW'(1);
        y0 = PW'(ty0_reg) + PW'(sy_reg);
        wl = PW'(wm1_reg);
        hl = PW'(hm1_reg);
        v0 = (x0 <= wl) && (y0 <= hl);
        v1 = two && (x1 <= wl) && (y0 <= hl);

        // tile walk
        sx_sum = {1'b0, sx_reg} + (two ? 4'd2 : 4'd1);
        sy_sum = {1'b0, sy_reg} + 4'd1;
        tx_sum = PW'(tx0_reg) + PW'(tile_w);
        ty_sum = PW'(ty0_reg) + PW'(tile_h);
        if (texel)
        begin
            if (sx_sum == tile_w)
            begin
                sx_next = '0;
                if (sy_sum == tile_h)
                begin
                    sy_next = '0;
                    if (tx_sum > wl)
                    begin
                        tx0_next = '0;
                        ty0_next = (ty_sum > hl) ? '0 : CW'(ty_sum);
                    end
                    else
                    begin
                        tx0_next = CW'(tx_sum);
                    end
                end
                else
                begin
                    sy_next = sy_sum[2:0];
                end
            end
            else
            begin
                sx_next = sx_sum[2:0];
            end
        end

        q_entry                = '0;
        q_entry.op             = req_type ? OP_TEXELS : OP_PAL_LOAD;
        q_entry.pal_addr       = palette_index;
        q_entry.slots[0].valid = v0;
        q_entry.slots[0].kind  = kind;
        q_entry.slots[0].value = req_type ? val0 : palette_word;
        q_entry.slots[0].pix_x = POS_W'(x0);
        q_entry.slots[0].pix_y = POS_W'(y0);
        q_entry.slots[0].done  = (x0 == wl) && (y0 == hl);
        q_entry.slots[1].valid = v1;
        q_entry.slots[1].kind  = kind;
        q_entry.slots[1].value = val1;
        q_entry.slots[1].pix_x = POS_W'(x1);
        q_entry.slots[1].pix_y = POS_W'(y0);
        q_entry.slots[1].done  = (x1 == wl) && (y0 == hl);

        q_push = (accept && !req_type && pal_ok) || (texel && (v0 || v1));

        // register writes restart the walk
        cfg_mode = cfg_data[2:0];
        if (cfg_we && (cfg_index == REG_CODING_MODE || cfg_index == REG_IMAGE_WIDTH
                       || cfg_index == REG_IMAGE_HEIGHT))
        begin
            tx0_next   = '0;
            ty0_next   = '0;
            sx_next    = '0;
            sy_next    = '0;
            held_next  = '0;
            phase_next = 1'b0;
            case (cfg_index)
                REG_CODING_MODE:
                begin
                    mode_next = (cfg_mode > 3'd4) ? MODE_RGB5A3 : coding_t'(cfg_mode);
                end
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data == '0)
                        wm1_next = '0;
                    else if (32'(cfg_data) > MAX_DIMENSION)
                        wm1_next = CW'(MAX_DIMENSION - 1);
                    else
                        wm1_next = CW'(cfg_data - CFG_DATA_W'(1));
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data == '0)
                        hm1_next = '0;
                    else if (32'(cfg_data) > MAX_DIMENSION)
                        hm1_next = CW'(MAX_DIMENSION - 1);
                    else
                        hm1_next = CW'(cfg_data - CFG_DATA_W'(1));
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RGB5A3;
            wm1_reg   <= '0;
            hm1_reg   <= '0;
            tx0_reg   <= '0;
            ty0_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            held_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            wm1_reg   <= wm1_next;
            hm1_reg   <= hm1_next;
            tx0_reg   <= tx0_next;
            ty0_reg   <= ty0_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/core/ttdec_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdec_back: execution side of the tiled texel decoder
// Applies palette loads, reads palette entries, expands colors and keeps
// the result queue that feeds the output ports.
// ----------------------------------------------------------------------------
module ttdec_back
    import ttdec_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [POS_W-1:0]   pix_x,
    output logic [POS_W-1:0]   pix_y,
    output logic [COLOR_W-1:0] red,
    output logic [COLOR_W-1:0] green,
    output logic [COLOR_W-1:0] blue,
    output logic [COLOR_W-1:0] alpha,
    output logic               image_done
);

    localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
    localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OQ_SUM_W = OQ_CNT_W + 1;

    logic                s2_valid_reg, s2_valid_next;
    entry_t              s2_entry_reg;
    logic                ram_we;
    logic [WORD_W-1:0]   rdata [2];

    result_t             oq_reg [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [OQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;

    logic                room;
    logic                wr_en [2];
    logic [OQ_PTR_W-1:0] wr_addr [2];
    result_t             res [2];
    logic [WORD_W-1:0]   word [2];
    rgba_t               color [2];
    logic [1:0]          n_push;
    logic                out_pop;
    result_t             head;

    ttdec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (q_head.pal_addr[PAL_AW-1:0]),
        .wdata   (q_head.slots[0].value),
        .raddr_a (q_head.slots[0].value[PAL_AW-1:0]),
        .raddr_b (q_head.slots[1].value[PAL_AW-1:0]),
        .rdata_a (rdata[0]),
        .rdata_b (rdata[1])
    );

    always_comb
    begin
        // keep room for what stage two holds plus the entry taken now
        room = (OQ_SUM_W'(oq_count_reg) + (s2_valid_reg ? OQ_SUM_W'(2) : OQ_SUM_W'(0)))
               <= OQ_SUM_W'(OUTQ_DEPTH - 2);
        q_pop         = !q_empty && room;
        ram_we        = q_pop && (q_head.op == OP_PAL_LOAD);
        s2_valid_next = q_pop && (q_head.op == OP_TEXELS);

        for (int k = 0; k < 2; k++)
        begin
            word[k] = s2_entry_reg.slots[k].value;
            if (s2_entry_reg.slots[k].kind == TEXEL_PALETTE)
            begin
                // palette indexes beyond the palette read as the word zero
                word[k] = (s2_entry_reg.slots[k].value >= WORD_W'(PALETTE_DEPTH))
                          ? '0 : rdata[k];
            end
            case (s2_entry_reg.slots[k].kind)
                TEXEL_ALPHA:
                begin
                    color[k] = {8'hFF, 8'hFF, 8'hFF, s2_entry_reg.slots[k].value[7:0]};
                end
                default:
                begin
                    color[k] = decode_rgb5a3(word[k]);
                end
            endcase
            res[k].pix_x      = s2_entry_reg.slots[k].pix_x;
            res[k].pix_y      = s2_entry_reg.slots[k].pix_y;
            res[k].color      = color[k];
            res[k].image_done = s2_entry_reg.slots[k].done;
            wr_en[k]          = s2_valid_reg && s2_entry_reg.slots[k].valid;
        end

        wr_addr[0] = oq_wr_reg;
        wr_addr[1] = oq_wr_reg + OQ_PTR_W'(wr_en[0]);
        n_push     = 2'(wr_en[0]) + 2'(wr_en[1]);
        out_pop    = pop && !empty;

        oq_wr_next    = oq_wr_reg + OQ_PTR_W'(n_push);
        oq_rd_next    = oq_rd_reg + OQ_PTR_W'(out_pop);
        oq_count_next = oq_count_reg + OQ_CNT_W'(n_push) - OQ_CNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_entry_reg <= q_head;
        end
        if (wr_en[0])
        begin
            oq_reg[wr_addr[0]] <= res[0];
        end
        if (wr_en[1])
        begin
            oq_reg[wr_addr[1]] <= res[1];
        end
    end

    assign head       = oq_reg[oq_rd_reg];
    assign empty      = (oq_count_reg == '0);
    assign pix_x      = head.pix_x;
    assign pix_y      = head.pix_y;
    assign red        = head.color.red;
    assign green      = head.color.green;
    assign blue       = head.color.blue;
    assign alpha      = head.color.alpha;
    assign image_done = head.image_done;

endmodule

/* rtl/core/tiled_texture_texel_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_texture_texel_decoder: tiled texture to raster RGBA decoder
// Decodes tiled palette, intensity and RGB5A3 texture data into pixels.
// ----------------------------------------------------------------------------
// Input queue: raise push with an item while full is low; the item transfers
// on that edge. An item is a palette load (req_type 0) or one pixel byte
// (req_type 1) in tiled storage order. Output queue: while empty is low the
// oldest pixel sits on pix_x/pix_y/red/green/blue/alpha/image_done, and it
// transfers on an edge with pop high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 coding
// mode, 1 width, 2 height) at once; each write restarts the tile walk.
// Path: a pixel's byte passes the front queue, then the palette read stage,
// into the result queue; while that lacks room it waits in the front queue.
// Throughput: one item per cycle while full is low. The result port moves one
// pixel per cycle, so the 4-bit codings, which make two pixels per byte, fill
// the result queue faster than it drains; palette loads and dropped padding
// texels cost nothing at the output.
// Reset: coding mode 0, 1x1 image, walk at the first tile, both queues
// empty; palette contents are undefined until loaded.
// Stall: with pop low the result queue fills, the back end stops taking
// entries, the front queue fills and full rises.
// ----------------------------------------------------------------------------
module tiled_texture_texel_decoder
    import ttdec_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  req_type,
    input  logic [INDEX_W-1:0]    palette_index,
    input  logic [WORD_W-1:0]     palette_word,
    input  logic [BYTE_W-1:0]     pixel_byte,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [POS_W-1:0]      pix_x,
    output logic [POS_W-1:0]      pix_y,
    output logic [COLOR_W-1:0]    red,
    output logic [COLOR_W-1:0]    green,
    output logic [COLOR_W-1:0]    blue,
    output logic [COLOR_W-1:0]    alpha,
    output logic                  image_done
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    entry_t q_entry;
    entry_t q_head;

    ttdec_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .req_type      (req_type),
        .palette_index (palette_index),
        .palette_word  (palette_word),
        .pixel_byte    (pixel_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    ttdec_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    ttdec_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .image_done (image_done)
    );

    // a transfer is taken whenever the front queue has a free slot
    assign full = q_full;

endmodule
